// ===== hdl/vil_pkg.sv =====
// Shared types and constants for the voxel index linearisation block.
// No dependencies; vil_if.sv, vil_front and the core import this package, vil_divider does not.
package vil_pkg;

	// Field widths
	localparam int IDX_W   = 10;
	localparam int DIM_W   = 11;
	localparam int ID_W    = 30;
	localparam int PLANE_W = 2 * IDX_W + 1;
	localparam int PROD_W  = ID_W + 1;
	localparam int CFG_W   = 2;

	// Largest usable grid size along any axis
	localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

	// Configuration register indexes
	localparam logic [CFG_W-1:0] CFG_DIM_X = 2'd0;
	localparam logic [CFG_W-1:0] CFG_DIM_Y = 2'd1;
	localparam logic [CFG_W-1:0] CFG_DIM_Z = 2'd2;

	// Action codes
	localparam logic ACT_TO_ID    = 1'b0;
	localparam logic ACT_TO_INDEX = 1'b1;

	typedef struct packed {
		logic             action;
		logic [IDX_W-1:0] index_i;
		logic [IDX_W-1:0] index_j;
		logic [IDX_W-1:0] index_k;
		logic [ID_W-1:0]  linear_id;
	} vil_req_t;

	typedef struct packed {
		logic [ID_W-1:0]  result_id;
		logic [IDX_W-1:0] out_i;
		logic [IDX_W-1:0] out_j;
		logic [IDX_W-1:0] out_k;
		logic             valid_res;
	} vil_res_t;

	// Front end result: linear id for action 0, request id for action 1
	typedef struct packed {
		logic               action;
		logic               ok;
		logic [ID_W-1:0]    value;
		logic [PLANE_W-1:0] plane;
	} vil_front_t;

	// Sideband through the plane divider
	typedef struct packed {
		logic            action;
		logic            ok;
		logic [ID_W-1:0] value;
	} vil_side1_t;

	// Sideband through the row divider
	typedef struct packed {
		logic             action;
		logic             ok;
		logic [ID_W-1:0]  value;
		logic [IDX_W-1:0] k;
	} vil_side2_t;

endpackage

// ===== hdl/vil_if.sv =====
// Request and result channel interfaces (valid, ready, payload).
// Depends on vil_pkg for the payload types.
interface vil_req_if;
	import vil_pkg::*;
	logic     valid;
	logic     ready;
	vil_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vil_res_if;
	import vil_pkg::*;
	logic     valid;
	logic     ready;
	vil_res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/vil_front.sv =====
// Three-stage front end: plane size, bound checks and the forward linear id.
// Depends on vil_pkg and the request interface in vil_if.sv.
module vil_front (
	input  logic               clk,
	input  logic               arst_n,
	vil_req_if.sink            req,
	input  logic [10:0]        dim_x,
	input  logic [10:0]        dim_y,
	input  logic [10:0]        dim_z,
	output logic               out_valid,
	input  logic               out_ready,
	output vil_pkg::vil_front_t out_data
);
	import vil_pkg::*;

	logic ld_s1, ld_s2, ld_s3;
	logic vld_s1, vld_s2, vld_s3;

	logic [2*DIM_W-1:0]       plane_full;
	logic [IDX_W+DIM_W-1:0]   jdx_c;
	logic                     usable_c, inb_c;

	logic                     act_s1, use_s1, inb_s1;
	logic [IDX_W-1:0]         i_s1, k_s1;
	logic [ID_W-1:0]          id_s1;
	logic [PLANE_W-1:0]       plane_s1;
	logic [IDX_W+DIM_W-1:0]   jdx_s1;

	logic [DIM_W-1:0]         mul_op;
	logic [PLANE_W+DIM_W-1:0] prod_full;

	logic                     act_s2, use_s2, inb_s2;
	logic [ID_W-1:0]          id_s2;
	logic [PLANE_W-1:0]       plane_s2;
	logic [PROD_W-1:0]        prod_s2;
	logic [IDX_W+DIM_W-1:0]   jdxi_s2;

	logic [PROD_W-1:0]        sum_c;

	// Advance a stage when it is empty or the next one moves
	assign ld_s3     = !vld_s3 || out_ready;
	assign ld_s2     = !vld_s2 || ld_s3;
	assign ld_s1     = !vld_s1 || ld_s2;
	assign req.ready = ld_s1;
	assign out_valid = vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (ld_s1) vld_s1 <= req.valid;
			if (ld_s2) vld_s2 <= vld_s1;
			if (ld_s3) vld_s3 <= vld_s2;
		end
	end

	// Stage 1: plane size, row offset and bound checks
	assign plane_full = dim_x * dim_y;
	assign jdx_c      = req.data.index_j * dim_x;
	assign usable_c   = (dim_x <= MAX_DIM) && (dim_y <= MAX_DIM) && (dim_z <= MAX_DIM);
	assign inb_c      = ({1'b0, req.data.index_i} < dim_x) &&
	                    ({1'b0, req.data.index_j} < dim_y) &&
	                    ({1'b0, req.data.index_k} < dim_z);

	always_ff @(posedge clk) begin
		if (ld_s1 && req.valid) begin
			act_s1   <= req.data.action;
			use_s1   <= usable_c;
			inb_s1   <= inb_c;
			i_s1     <= req.data.index_i;
			k_s1     <= req.data.index_k;
			id_s1    <= req.data.linear_id;
			// only unusable grids overflow the plane width
			plane_s1 <= plane_full[PLANE_W-1:0];
			jdx_s1   <= jdx_c;
		end
	end

	// Stage 2: one shared multiplier, plane by depth or by the z index
	assign mul_op    = (act_s1 == ACT_TO_INDEX) ? dim_z : {1'b0, k_s1};
	assign prod_full = plane_s1 * mul_op;

	always_ff @(posedge clk) begin
		if (ld_s2 && vld_s1) begin
			act_s2   <= act_s1;
			use_s2   <= use_s1;
			inb_s2   <= inb_s1;
			id_s2    <= id_s1;
			plane_s2 <= plane_s1;
			prod_s2  <= prod_full[PROD_W-1:0];
			jdxi_s2  <= jdx_s1 + (IDX_W+DIM_W)'(i_s1);
		end
	end

	// Stage 3: final sum and range check
	assign sum_c = prod_s2 + PROD_W'(jdxi_s2);

	always_ff @(posedge clk) begin
		if (ld_s3 && vld_s2) begin
			out_data.action <= act_s2;
			out_data.plane  <= plane_s2;
			if (act_s2 == ACT_TO_INDEX) begin
				out_data.ok    <= use_s2 && ({1'b0, id_s2} < prod_s2);
				out_data.value <= id_s2;
			end else begin
				out_data.ok    <= use_s2 && inb_s2;
				out_data.value <= sum_c[ID_W-1:0];
			end
		end
	end

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (vld_s1 && vld_s2 && vld_s3))
		else $error("front end stalls with an empty stage");
`endif

endmodule

// ===== hdl/vil_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband word alongside; depends on no package.
module vil_divider #(
	parameter int NUM_W  = 30,
	parameter int DEN_W  = 21,
	parameter int Q_W    = 10,
	parameter int SIDE_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [Q_W-1:0]    out_quo,
	output logic [NUM_W-1:0]  out_rem,
	output logic [SIDE_W-1:0] out_side
);

	localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [Q_W-1:0]    vld_s;
	logic [NUM_W-1:0]  rem_s  [Q_W];
	logic [DEN_W-1:0]  den_s  [Q_W];
	logic [Q_W-1:0]    quo_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];

	logic [Q_W-1:0]    vin, ld, take;
	logic [NUM_W-1:0]  rem_in  [Q_W];
	logic [DEN_W-1:0]  den_in  [Q_W];
	logic [Q_W-1:0]    quo_in  [Q_W];
	logic [SIDE_W-1:0] side_in [Q_W];
	logic [CW-1:0]     den_sh  [Q_W];
	logic [CW-1:0]     diff    [Q_W];
	logic [NUM_W-1:0]  rem_nx  [Q_W];
	logic [Q_W-1:0]    quo_nx  [Q_W];

	// One compare-subtract per stage; a stage loads while the output moves or it or any later stage is free
	always_comb begin
		for (int s = 0; s < Q_W; s++) begin
			if (s == 0) begin
				vin[s]     = in_valid;
				rem_in[s]  = in_num;
				den_in[s]  = in_den;
				quo_in[s]  = '0;
				side_in[s] = in_side;
			end else begin
				vin[s]     = vld_s[s-1];
				rem_in[s]  = rem_s[s-1];
				den_in[s]  = den_s[s-1];
				quo_in[s]  = quo_s[s-1];
				side_in[s] = side_s[s-1];
			end
			den_sh[s] = CW'(den_in[s]) << (Q_W - 1 - s);
			take[s]   = CW'(rem_in[s]) >= den_sh[s];
			diff[s]   = CW'(rem_in[s]) - den_sh[s];
			rem_nx[s] = take[s] ? diff[s][NUM_W-1:0] : rem_in[s];
			quo_nx[s] = quo_in[s] | (take[s] ? (Q_W'(1) << (Q_W - 1 - s)) : '0);
			ld[s]     = out_ready || !(&(vld_s | ((Q_W'(1) << s) - Q_W'(1))));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int s = 0; s < Q_W; s++) begin
				if (ld[s]) vld_s[s] <= vin[s];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < Q_W; s++) begin
			if (ld[s] && vin[s]) begin
				rem_s[s]  <= rem_nx[s];
				den_s[s]  <= den_in[s];
				quo_s[s]  <= quo_nx[s];
				side_s[s] <= side_in[s];
			end
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = vld_s[Q_W-1];
	assign out_quo   = quo_s[Q_W-1];
	assign out_rem   = rem_s[Q_W-1];
	assign out_side  = side_s[Q_W-1];

`ifndef SYNTHESIS
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_quo) && $stable(out_side))
		else $error("divider dropped or changed a stalled result");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&vld_s))
		else $error("divider stalls with a free stage");
`endif

endmodule

// ===== hdl/voxel_index_linearize_core.sv =====
// Requests pass the front end, the plane divider, the row divider and the output register in order.
// Throughput: one request per cycle unless stalled; both dividers pipeline one quotient bit per stage.
// A stalled output fills bubbles first, then holds every stage in place.
// Reset (arst_n low, asynchronous): grid sizes clear to zero and all stages empty.
// Depends on vil_pkg, vil_if.sv, vil_front and vil_divider.
module voxel_index_linearize_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [10:0] wr_data,
	vil_req_if.sink     req,
	vil_res_if.source   res
);
	import vil_pkg::*;

	logic [DIM_W-1:0] dim_x_q, dim_y_q, dim_z_q;

	logic       f_valid, f_ready;
	vil_front_t f_data;

	vil_side1_t        side1_in, side1_out;
	logic [$bits(vil_side1_t)-1:0] d1_side;
	logic              d1_valid, d1_ready;
	logic [IDX_W-1:0]  d1_quo;
	logic [ID_W-1:0]   d1_rem;

	vil_side2_t        side2_in, side2_out;
	logic [$bits(vil_side2_t)-1:0] d2_side;
	logic              d2_valid, d2_ready;
	logic [IDX_W-1:0]  d2_quo;
	logic [PLANE_W-1:0] d2_rem;

	logic     res_vld_q;
	vil_res_t res_q;
	logic     ld_out;
	logic     to_index;

	// Grid size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= '0;
			dim_y_q <= '0;
			dim_z_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_DIM_X: dim_x_q <= wr_data;
				CFG_DIM_Y: dim_y_q <= wr_data;
				CFG_DIM_Z: dim_z_q <= wr_data;
				default: ;
			endcase
		end
	end

	vil_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.dim_x     (dim_x_q),
		.dim_y     (dim_y_q),
		.dim_z     (dim_z_q),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_data  (f_data)
	);

	// Split off the z index: id over the plane size
	assign side1_in.action = f_data.action;
	assign side1_in.ok     = f_data.ok;
	assign side1_in.value  = f_data.value;

	vil_divider #(
		.NUM_W  (ID_W),
		.DEN_W  (PLANE_W),
		.Q_W    (IDX_W),
		.SIDE_W ($bits(vil_side1_t))
	) u_div_plane (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_num    (f_data.value),
		.in_den    (f_data.plane),
		.in_side   (side1_in),
		.out_valid (d1_valid),
		.out_ready (d1_ready),
		.out_quo   (d1_quo),
		.out_rem   (d1_rem),
		.out_side  (d1_side)
	);

	// Split the remainder into y and x: remainder over the row size
	assign side1_out       = vil_side1_t'(d1_side);
	assign side2_in.action = side1_out.action;
	assign side2_in.ok     = side1_out.ok;
	assign side2_in.value  = side1_out.value;
	assign side2_in.k      = d1_quo;

	vil_divider #(
		.NUM_W  (PLANE_W),
		.DEN_W  (DIM_W),
		.Q_W    (IDX_W),
		.SIDE_W ($bits(vil_side2_t))
	) u_div_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d1_valid),
		.in_ready  (d1_ready),
		.in_num    (d1_rem[PLANE_W-1:0]),
		.in_den    (dim_x_q),
		.in_side   (side2_in),
		.out_valid (d2_valid),
		.out_ready (d2_ready),
		.out_quo   (d2_quo),
		.out_rem   (d2_rem),
		.out_side  (d2_side)
	);

	assign side2_out = vil_side2_t'(d2_side);
	assign to_index  = (side2_out.action == ACT_TO_INDEX);

	// Output register; zero every field of a request outside the grid
	assign ld_out   = !res_vld_q || res.ready;
	assign d2_ready = ld_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (ld_out) begin
			res_vld_q <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out && d2_valid) begin
			res_q.valid_res <= side2_out.ok;
			res_q.result_id <= (side2_out.ok && !to_index) ? side2_out.value : '0;
			res_q.out_k     <= (side2_out.ok && to_index) ? side2_out.k : '0;
			res_q.out_j     <= (side2_out.ok && to_index) ? d2_quo : '0;
			res_q.out_i     <= (side2_out.ok && to_index) ? d2_rem[IDX_W-1:0] : '0;
		end
	end

	assign res.valid = res_vld_q;
	assign res.data  = res_q;

`ifndef SYNTHESIS
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.data.valid_res |-> (res.data.result_id == '0) &&
		(res.data.out_i == '0) && (res.data.out_j == '0) && (res.data.out_k == '0))
		else $error("rejected request carries non-zero fields");
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(d2_valid))
		else $error("result appeared without a divider output");
`endif

endmodule
